// ===== src/rgsag_pkg.sv =====
`default_nettype none
package rgsag_pkg;

  // field widths
  localparam int DIM_BITS      = 16;
  localparam int LAYER_BITS    = 8;
  localparam int ADDR_BITS     = 40;
  localparam int CFG_DATA_BITS = (DIM_BITS > LAYER_BITS) ? DIM_BITS : LAYER_BITS;
  localparam int CFG_IDX_BITS  = 3;

  // divider step counter
  localparam int DIV_CNT_BITS  = $clog2(DIM_BITS);

  // shared multiplier operand and product widths
  localparam int MUL_A_BITS    = 2 * DIM_BITS;
  localparam int MUL_B_BITS    = CFG_DATA_BITS;
  localparam int MUL_P_BITS    = MUL_A_BITS + MUL_B_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_ROWS    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_COLS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_ROWS    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_COLS    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER_COUNT = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_PLANE,
    ST_MUL_LAYER,
    ST_MUL_ROW,
    ST_SUM
  } state_t;

  // divider handshake
  typedef struct packed {
    logic                start;
    logic [DIM_BITS-1:0] dividend;
    logic [DIM_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIM_BITS-1:0] quotient;
    logic [DIM_BITS-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/rgsag_div.sv =====
`default_nettype none
module rgsag_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rgsag_pkg::div_req_t req,
  output rgsag_pkg::div_rsp_t     rsp
);

  logic                                 busy;
  logic                                 done;
  logic [rgsag_pkg::DIV_CNT_BITS-1:0]   cnt;
  logic [rgsag_pkg::DIM_BITS-1:0]       divisor;
  logic [rgsag_pkg::DIM_BITS-1:0]       quo;
  logic [rgsag_pkg::DIM_BITS-1:0]       rem;
  logic [rgsag_pkg::DIM_BITS:0]         rem_sh;
  logic [rgsag_pkg::DIM_BITS:0]         diff;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem, quo[rgsag_pkg::DIM_BITS-1]};
    diff   = rem_sh - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rgsag_pkg::DIV_CNT_BITS'(rgsag_pkg::DIM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      quo     <= req.dividend;
      rem     <= '0;
    end else if (busy) begin
      if (!diff[rgsag_pkg::DIM_BITS]) begin
        rem <= diff[rgsag_pkg::DIM_BITS-1:0];
        quo <= {quo[rgsag_pkg::DIM_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[rgsag_pkg::DIM_BITS-1:0];
        quo <= {quo[rgsag_pkg::DIM_BITS-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

// ===== src/regular_grid_sample_address_gen_top.sv =====
`default_nettype none
// restart beat: two divisions through one bit-per-cycle restoring divider, then the
// plane size and the address products
// advance beat: two passes through one shared multiplier and a final add; a result
// held in the output register stalls both; no new beat is taken before it is loaded
// reset: scan at the first cell with all sizes 1, sizes read from registers on restart
module regular_grid_sample_address_gen_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wen,
  input  wire logic [rgsag_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rgsag_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  restart,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [rgsag_pkg::ADDR_BITS-1:0]            cell_index,
  output logic [rgsag_pkg::LAYER_BITS-1:0]           layer,
  output logic [rgsag_pkg::DIM_BITS-1:0]             out_row,
  output logic [rgsag_pkg::DIM_BITS-1:0]             out_col,
  output logic [rgsag_pkg::DIM_BITS-1:0]             src_row,
  output logic [rgsag_pkg::DIM_BITS-1:0]             src_col,
  output logic                                       row_end,
  output logic                                       scan_end
);

  localparam int DB = rgsag_pkg::DIM_BITS;
  localparam int LB = rgsag_pkg::LAYER_BITS;
  localparam int AB = rgsag_pkg::ADDR_BITS;

  rgsag_pkg::state_t state, state_next;

  // configuration registers
  logic [DB-1:0] reg_src_rows, reg_src_cols, reg_out_rows, reg_out_cols;
  logic [LB-1:0] reg_layers;

  // sizes captured at restart
  logic [DB-1:0] lat_src_rows, lat_src_cols, lat_out_rows, lat_out_cols;
  logic [LB-1:0] lat_layers;

  // step terms
  logic [DB-1:0] row_q, row_r, row_start, col_q, col_r, col_start;

  // scan position
  logic [LB-1:0] layer_cnt;
  logic [DB-1:0] row_cnt, col_cnt, row_pos, row_rem, col_pos, col_rem;

  // address path
  logic [rgsag_pkg::MUL_A_BITS-1:0] plane;
  logic [rgsag_pkg::MUL_A_BITS-1:0] mul_a;
  logic [rgsag_pkg::MUL_B_BITS-1:0] mul_b;
  logic [rgsag_pkg::MUL_P_BITS-1:0] mul_p;
  logic [rgsag_pkg::MUL_P_BITS-1:0] prod;
  logic [AB-1:0]                    acc;
  logic [AB-1:0]                    addr_sum;

  rgsag_pkg::div_req_t div_req;
  rgsag_pkg::div_rsp_t div_rsp;

  logic accept, out_load, out_free;
  logic col_last, row_last, layer_last;
  logic [DB:0] col_rem_sum, row_rem_sum;
  logic col_wrap, row_wrap;

  rgsag_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_src_rows <= DB'(1);
      reg_src_cols <= DB'(1);
      reg_out_rows <= DB'(1);
      reg_out_cols <= DB'(1);
      reg_layers   <= LB'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        rgsag_pkg::CFG_SRC_ROWS:    reg_src_rows <= DB'(cfg_data);
        rgsag_pkg::CFG_SRC_COLS:    reg_src_cols <= DB'(cfg_data);
        rgsag_pkg::CFG_OUT_ROWS:    reg_out_rows <= DB'(cfg_data);
        rgsag_pkg::CFG_OUT_COLS:    reg_out_cols <= DB'(cfg_data);
        rgsag_pkg::CFG_LAYER_COUNT: reg_layers   <= LB'(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_ready = (state == rgsag_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // end-of-dimension flags and remainder stepping
  always_comb begin
    col_last    = ({1'b0, col_cnt} + 1'b1) >= {1'b0, lat_out_cols};
    row_last    = ({1'b0, row_cnt} + 1'b1) >= {1'b0, lat_out_rows};
    layer_last  = ({1'b0, layer_cnt} + 1'b1) >= {1'b0, lat_layers};
    col_rem_sum = {1'b0, col_rem} + {1'b0, col_r};
    row_rem_sum = {1'b0, row_rem} + {1'b0, row_r};
    col_wrap    = col_rem_sum >= {1'b0, lat_out_cols};
    row_wrap    = row_rem_sum >= {1'b0, lat_out_rows};
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      rgsag_pkg::ST_PLANE: begin
        mul_a = rgsag_pkg::MUL_A_BITS'(lat_src_rows);
        mul_b = rgsag_pkg::MUL_B_BITS'(lat_src_cols);
      end
      rgsag_pkg::ST_MUL_LAYER: begin
        mul_a = plane;
        mul_b = rgsag_pkg::MUL_B_BITS'(layer_cnt);
      end
      default: begin
        mul_a = rgsag_pkg::MUL_A_BITS'(lat_src_cols);
        mul_b = rgsag_pkg::MUL_B_BITS'(row_pos);
      end
    endcase
    mul_p    = rgsag_pkg::MUL_P_BITS'(mul_a) * rgsag_pkg::MUL_P_BITS'(mul_b);
    addr_sum = acc + AB'(prod) + AB'(col_pos);
  end

  // sequencer: next state, divider requests and output load
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = lat_src_rows;
    div_req.divisor  = lat_out_rows;
    out_load         = 1'b0;
    case (state)
      rgsag_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = restart ? rgsag_pkg::ST_LOAD : rgsag_pkg::ST_MUL_LAYER;
        end
      end
      rgsag_pkg::ST_LOAD: begin
        div_req.start = 1'b1;
        state_next    = rgsag_pkg::ST_DIV_ROW;
      end
      rgsag_pkg::ST_DIV_ROW: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = lat_src_cols;
          div_req.divisor  = lat_out_cols;
          state_next       = rgsag_pkg::ST_DIV_COL;
        end
      end
      rgsag_pkg::ST_DIV_COL: begin
        if (div_rsp.done) begin
          state_next = rgsag_pkg::ST_PLANE;
        end
      end
      rgsag_pkg::ST_PLANE:     state_next = rgsag_pkg::ST_MUL_LAYER;
      rgsag_pkg::ST_MUL_LAYER: state_next = rgsag_pkg::ST_MUL_ROW;
      rgsag_pkg::ST_MUL_ROW:   state_next = rgsag_pkg::ST_SUM;
      rgsag_pkg::ST_SUM: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = rgsag_pkg::ST_IDLE;
        end
      end
      default: state_next = rgsag_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgsag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // captured sizes, step terms and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_src_rows <= DB'(1);
      lat_src_cols <= DB'(1);
      lat_out_rows <= DB'(1);
      lat_out_cols <= DB'(1);
      lat_layers   <= LB'(1);
      plane        <= rgsag_pkg::MUL_A_BITS'(1);
      row_q        <= '0;
      row_r        <= '0;
      row_start    <= '0;
      col_q        <= '0;
      col_r        <= '0;
      col_start    <= '0;
      layer_cnt    <= '0;
      row_cnt      <= '0;
      col_cnt      <= '0;
      row_pos      <= '0;
      row_rem      <= '0;
      col_pos      <= '0;
      col_rem      <= '0;
    end else begin
      case (state)
        rgsag_pkg::ST_IDLE: begin
          if (accept && restart) begin
            // zero sizes count as one
            lat_src_rows <= (reg_src_rows == '0) ? DB'(1) : reg_src_rows;
            lat_src_cols <= (reg_src_cols == '0) ? DB'(1) : reg_src_cols;
            lat_out_rows <= (reg_out_rows == '0) ? DB'(1) : reg_out_rows;
            lat_out_cols <= (reg_out_cols == '0) ? DB'(1) : reg_out_cols;
            lat_layers   <= (reg_layers == '0) ? LB'(1) : reg_layers;
          end else if (accept) begin
            // advance one output cell
            if (!col_last) begin
              col_cnt <= col_cnt + 1'b1;
              col_pos <= col_pos + col_q + DB'(col_wrap);
              col_rem <= col_wrap ? DB'(col_rem_sum - {1'b0, lat_out_cols})
                                  : DB'(col_rem_sum);
            end else begin
              col_cnt <= '0;
              col_pos <= col_start;
              col_rem <= '0;
              if (!row_last) begin
                row_cnt <= row_cnt + 1'b1;
                row_pos <= row_pos + row_q + DB'(row_wrap);
                row_rem <= row_wrap ? DB'(row_rem_sum - {1'b0, lat_out_rows})
                                    : DB'(row_rem_sum);
              end else begin
                row_cnt   <= '0;
                row_pos   <= row_start;
                row_rem   <= '0;
                layer_cnt <= layer_last ? '0 : layer_cnt + 1'b1;
              end
            end
          end
        end
        rgsag_pkg::ST_DIV_ROW: begin
          if (div_rsp.done) begin
            row_q     <= div_rsp.quotient;
            row_r     <= div_rsp.remainder;
            row_start <= div_rsp.quotient >> 1;
          end
        end
        rgsag_pkg::ST_DIV_COL: begin
          if (div_rsp.done) begin
            // quotient by twice the size is half the plain quotient
            col_q     <= div_rsp.quotient;
            col_r     <= div_rsp.remainder;
            col_start <= div_rsp.quotient >> 1;
            layer_cnt <= '0;
            row_cnt   <= '0;
            col_cnt   <= '0;
            row_pos   <= row_start;
            row_rem   <= '0;
            col_pos   <= div_rsp.quotient >> 1;
            col_rem   <= '0;
          end
        end
        rgsag_pkg::ST_PLANE: begin
          plane <= mul_p[rgsag_pkg::MUL_A_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // address accumulation through the shared multiplier
  always_ff @(posedge clk) begin
    case (state)
      rgsag_pkg::ST_MUL_LAYER: prod <= mul_p;
      rgsag_pkg::ST_MUL_ROW: begin
        acc  <= AB'(prod);
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_index <= addr_sum;
      layer      <= layer_cnt;
      out_row    <= row_cnt;
      out_col    <= col_cnt;
      src_row    <= row_pos;
      src_col    <= col_pos;
      row_end    <= col_last;
      scan_end   <= col_last && row_last && layer_last;
    end
  end

endmodule
`default_nettype wire

// ===== tb/regular_grid_sample_address_gen_top_test.sv =====
`default_nettype none
module regular_grid_sample_address_gen_top_test;
  import rgsag_pkg::*;

  // one sampled cell as the block reports it
  typedef struct {
    logic [ADDR_BITS-1:0]  cell_index;
    logic [LAYER_BITS-1:0] layer;
    logic [DIM_BITS-1:0]   out_row;
    logic [DIM_BITS-1:0]   out_col;
    logic [DIM_BITS-1:0]   src_row;
    logic [DIM_BITS-1:0]   src_col;
    logic                  row_end;
    logic                  scan_end;
  } scan_cell_t;

  // clock, reset and block ports
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wen = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     restart = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ADDR_BITS-1:0]     cell_index;
  logic [LAYER_BITS-1:0]    layer;
  logic [DIM_BITS-1:0]      out_row;
  logic [DIM_BITS-1:0]      out_col;
  logic [DIM_BITS-1:0]      src_row;
  logic [DIM_BITS-1:0]      src_col;
  logic                     row_end;
  logic                     scan_end;

  regular_grid_sample_address_gen_top u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // size registers as written, and the copy the scan runs on
  logic [DIM_BITS-1:0]   reg_src_rows = DIM_BITS'(1), reg_src_cols = DIM_BITS'(1);
  logic [DIM_BITS-1:0]   reg_out_rows = DIM_BITS'(1), reg_out_cols = DIM_BITS'(1);
  logic [LAYER_BITS-1:0] reg_layers = LAYER_BITS'(1);
  int unsigned sz_src_rows = 1, sz_src_cols = 1, sz_out_rows = 1, sz_out_cols = 1;
  int unsigned sz_layers = 1;

  // scan position and quotient/remainder stepping terms
  int unsigned layer_ctr = 0, row_ctr = 0, col_ctr = 0;
  int unsigned row_pos = 0, row_rem = 0, col_pos = 0, col_rem = 0;
  int unsigned row_step = 0, row_frac = 0, row_start = 0;
  int unsigned col_step = 0, col_frac = 0, col_start = 0;

  // stimulus and expected cells
  bit         step_queue[$];
  scan_cell_t due_cells[$];
  scan_cell_t want;

  int tx_idle_pct = 22;
  int rx_idle_pct = 74;
  logic rx_hold = 1'b0;
  bit squeeze_on = 1'b0;
  logic drv_busy;

  int fail_count = 0;
  int beats_checked = 0;
  int restarts_sent = 0;
  int scan_ends_seen = 0;
  int settings_used = 0;

  function automatic int unsigned at_least_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // append one beat to the stimulus list
  function automatic void add_step(input bit s);
    step_queue.insert(step_queue.size(), s);
  endfunction

  // next sampled cell for one beat: restart or advance the scan
  function automatic scan_cell_t step_scan(input logic from_start);
    scan_cell_t c;
    longint unsigned addr;
    if (from_start) begin
      sz_src_rows = at_least_one(32'(reg_src_rows));
      sz_src_cols = at_least_one(32'(reg_src_cols));
      sz_out_rows = at_least_one(32'(reg_out_rows));
      sz_out_cols = at_least_one(32'(reg_out_cols));
      sz_layers   = at_least_one(32'(reg_layers));
      row_step  = sz_src_rows / sz_out_rows;
      row_frac  = sz_src_rows % sz_out_rows;
      row_start = sz_src_rows / (2 * sz_out_rows);
      col_step  = sz_src_cols / sz_out_cols;
      col_frac  = sz_src_cols % sz_out_cols;
      col_start = sz_src_cols / (2 * sz_out_cols);
      layer_ctr = 0;
      row_ctr   = 0;
      col_ctr   = 0;
      row_pos   = row_start;
      row_rem   = 0;
      col_pos   = col_start;
      col_rem   = 0;
    end else if (col_ctr + 1 < sz_out_cols) begin
      col_ctr++;
      col_pos += col_step;
      col_rem += col_frac;
      if (col_rem >= sz_out_cols) begin
        col_rem -= sz_out_cols;
        col_pos++;
      end
    end else begin
      col_ctr = 0;
      col_pos = col_start;
      col_rem = 0;
      if (row_ctr + 1 < sz_out_rows) begin
        row_ctr++;
        row_pos += row_step;
        row_rem += row_frac;
        if (row_rem >= sz_out_rows) begin
          row_rem -= sz_out_rows;
          row_pos++;
        end
      end else begin
        row_ctr = 0;
        row_pos = row_start;
        row_rem = 0;
        layer_ctr = (layer_ctr + 1 < sz_layers) ? layer_ctr + 1 : 0;
      end
    end
    addr = longint'(layer_ctr) * longint'(sz_src_rows) * longint'(sz_src_cols)
         + longint'(row_pos) * longint'(sz_src_cols) + longint'(col_pos);
    c.cell_index = addr[ADDR_BITS-1:0];
    c.layer      = layer_ctr[LAYER_BITS-1:0];
    c.out_row    = row_ctr[DIM_BITS-1:0];
    c.out_col    = col_ctr[DIM_BITS-1:0];
    c.src_row    = row_pos[DIM_BITS-1:0];
    c.src_col    = col_pos[DIM_BITS-1:0];
    c.row_end    = (col_ctr + 1 >= sz_out_cols);
    c.scan_end   = c.row_end && (row_ctr + 1 >= sz_out_rows) && (layer_ctr + 1 >= sz_layers);
    return c;
  endfunction

  // input driver: holds a beat until taken, then maybe offers the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      restart  <= 1'b0;
    end else begin
      drv_busy = in_valid;
      if (in_valid && in_ready) begin
        due_cells.insert(due_cells.size(), step_scan(restart));
        if (restart) restarts_sent++;
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (step_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          restart  <= step_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: check each taken beat against the oldest expected cell
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (scan_end) scan_ends_seen++;
        if (due_cells.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output beat: idx=%h layer=%0d row=%0d col=%0d",
                     cell_index, layer, out_row, out_col);
        end else begin
          want = due_cells.pop_front();
          if (cell_index !== want.cell_index || layer !== want.layer ||
              out_row !== want.out_row || out_col !== want.out_col ||
              src_row !== want.src_row || src_col !== want.src_col ||
              row_end !== want.row_end || scan_end !== want.scan_end) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch on beat %0d", beats_checked);
              $display("  expected idx=%h layer=%0d pos=%0d,%0d src=%0d,%0d ends=%b%b",
                       want.cell_index, want.layer, want.out_row, want.out_col,
                       want.src_row, want.src_col, want.row_end, want.scan_end);
              $display("  actual   idx=%h layer=%0d pos=%0d,%0d src=%0d,%0d ends=%b%b",
                       cell_index, layer, out_row, out_col, src_row, src_col,
                       row_end, scan_end);
            end
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (squeeze_on);
    repeat (30) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_SRC_ROWS:    reg_src_rows = val;
      CFG_SRC_COLS:    reg_src_cols = val;
      CFG_OUT_ROWS:    reg_out_rows = val;
      CFG_OUT_COLS:    reg_out_cols = val;
      CFG_LAYER_COUNT: reg_layers   = val[LAYER_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [CFG_DATA_BITS-1:0] s_rows,
                           input logic [CFG_DATA_BITS-1:0] s_cols,
                           input logic [CFG_DATA_BITS-1:0] o_rows,
                           input logic [CFG_DATA_BITS-1:0] o_cols,
                           input logic [CFG_DATA_BITS-1:0] layers);
    write_reg(CFG_SRC_ROWS, s_rows);
    write_reg(CFG_SRC_COLS, s_cols);
    write_reg(CFG_OUT_ROWS, o_rows);
    write_reg(CFG_OUT_COLS, o_cols);
    write_reg(CFG_LAYER_COUNT, layers);
    settings_used++;
  endtask

  // wait until every queued beat went in and every expected cell came out
  task automatic settle();
    do @(negedge clk);
    while (step_queue.size() != 0 || in_valid || due_cells.size() != 0);
  endtask

  // main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // advance before any restart, then restart and wrap on the unit scan
    step_queue = '{1'b0, 1'b0, 1'b1, 1'b0};
    settle();

    // largest sources, one output row, full layer count
    set_sizes(16'hFFFF, 16'hFFFF, 16'd1, 16'd2, 16'd255);
    step_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    settle();

    // zero sizes: old sizes hold until restart, then everything acts as 1
    set_sizes(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    step_queue = '{1'b0, 1'b1, 1'b0, 1'b0};
    settle();

    // largest output grid, single source column, layer write with high bits set
    set_sizes(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'h0102);
    step_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    settle();

    // random sizes, mostly small so scans wrap, with rare restarts
    for (int k = 0; k < 8; k++) begin
      if (k == 2) begin
        tx_idle_pct = 74;
        rx_idle_pct = 22;
      end
      if (k == 5) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (k != 5 && $urandom_range(3) == 0)
        set_sizes(CFG_DATA_BITS'($urandom_range(65535)),
                  CFG_DATA_BITS'($urandom_range(65535)),
                  CFG_DATA_BITS'($urandom_range(65535)),
                  CFG_DATA_BITS'($urandom_range(65535)),
                  CFG_DATA_BITS'($urandom_range(65535)));
      else
        set_sizes(CFG_DATA_BITS'($urandom_range(1, 30)),
                  CFG_DATA_BITS'($urandom_range(1, 30)),
                  CFG_DATA_BITS'($urandom_range(1, 4)),
                  CFG_DATA_BITS'($urandom_range(1, 6)),
                  CFG_DATA_BITS'($urandom_range(1, 3)));
      add_step($urandom_range(4) != 0);
      repeat (96) add_step($urandom_range(49) == 0);
      if (k == 5) squeeze_on = 1'b1;
      settle();
    end

    repeat (40) @(posedge clk);
    $display("checked %0d output beats over %0d size settings", beats_checked, settings_used);
    $display("%0d restarts, %0d complete scans seen", restarts_sent, scan_ends_seen);
    if (fail_count == 0 && due_cells.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #2400000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
